[hdl/sde_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_pkg - shared types and constants for the snapshot delta encoder
// Request and result structs, result kinds, the record job handed from the
// front end to the back end, and the bank release returned by the back end.
// ----------------------------------------------------------------------------
package sde_pkg;

	// Default geometry
	localparam int SDE_RECORD_WORDS = 13;
	localparam int SDE_MAX_BODIES   = 4096;
	localparam int SDE_JOBQ_DEPTH   = 2;

	// Bodies per mask byte
	localparam int GROUP_SIZE = 8;
	localparam int GROUP_BITS = $clog2(GROUP_SIZE);

	// Result kinds
	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_MASK  = 2'd1,
		KIND_COUNT = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Input request
	typedef struct packed {
		logic [31:0] base_word;
		logic [31:0] target_word;
		logic        final_word;
	} in_t;

	// Result item
	typedef struct packed {
		kind_t       kind;
		logic [31:0] payload;
		logic [11:0] body_index;
		logic        run_end;
	} out_t;

	// Work for the back end, one per result-bearing record end or error
	typedef struct packed {
		logic        err;
		logic        words;
		logic        bank;
		logic [11:0] body_idx;
		logic        mask_en;
		logic [7:0]  mask;
		logic [11:0] mask_idx;
		logic        count_en;
		logic [31:0] count;
	} job_t;

	// Record buffer write
	typedef struct packed {
		logic        en;
		logic        bank;
		logic [31:0] data;
	} wr_t;

	// Bank handed back once its words are out
	typedef struct packed {
		logic vld;
		logic bank;
	} rel_t;

endpackage : sde_pkg
`default_nettype wire

[hdl/snapshot_delta_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// snapshot_delta_encoder - bitmask delta encoder for paired snapshots
// Base and target words enter together as one request per cycle; each group
// of RECORD_WORDS words is one body record. A changed record comes out as its
// target words, a mask byte follows every 8 bodies and at snapshot end, then
// the body count. A snapshot that ends inside a record, or a record beyond
// MAX_BODIES, gives one size-error result and the encoder starts over.
// Input side: push/full, a request is taken when push is high and full low.
// Result side: empty/pop, the oldest result sits on result while empty is low.
// Run_end marks the last result caused by one request.
// A record end's job passes the job queue and the result register before its
// first result shows. Requests go in at one per cycle while full is low;
// results leave at one per cycle while popped. Records are double buffered,
// so a changed record drains its words while the next record fills; full rises
// when both banks hold undrained records or the two-entry job queue is full.
// Reset clears all control state; results not yet popped are dropped.
// A stalled receiver backs up the job queue and then the input side.
// ----------------------------------------------------------------------------
module snapshot_delta_encoder import sde_pkg::*; #(
	parameter int RECORD_WORDS = SDE_RECORD_WORDS,
	parameter int MAX_BODIES   = SDE_MAX_BODIES,
	parameter int JOBQ_DEPTH   = SDE_JOBQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire in_t  item,
	output logic      empty,
	input  wire logic pop,
	output out_t      result
);

	localparam int PW = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;

	wr_t           wr;
	logic [PW-1:0] wr_pos;
	rel_t          rel;
	logic          job_push;
	job_t          job_in;
	logic          job_full;
	logic          job_pop;
	job_t          job_head;
	logic          job_empty;

	// Front end: intake and classification
	sde_front #(
		.RECORD_WORDS (RECORD_WORDS),
		.MAX_BODIES   (MAX_BODIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.wr       (wr),
		.wr_pos   (wr_pos),
		.rel      (rel),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	// Job queue
	sde_jobq #(
		.DEPTH (JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_pop),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	// Back end: result sequencing
	sde_back #(
		.RECORD_WORDS (RECORD_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.wr_pos    (wr_pos),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.rel       (rel),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule : snapshot_delta_encoder
`default_nettype wire

[hdl/sde_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_front - request intake and record classification
// Writes target words into the free record bank, tracks differences, body
// count and mask byte; one job per size error or result-bearing record end.
// ----------------------------------------------------------------------------
module sde_front import sde_pkg::*; #(
	parameter int RECORD_WORDS = SDE_RECORD_WORDS,
	parameter int MAX_BODIES   = SDE_MAX_BODIES,
	localparam int PW = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire in_t           item,
	output wr_t                wr,
	output logic [PW-1:0]      wr_pos,
	input  wire rel_t          rel,
	output logic               job_push,
	output job_t               job,
	input  wire logic          job_full
);

	localparam int BW = $clog2(MAX_BODIES + 1);

	logic [PW-1:0] pos_q;
	logic          differs_q;
	logic [BW-1:0] bodies_q;
	logic [7:0]    mask_q;
	logic          wb_q;
	logic [1:0]    busy_q;

	logic          rec_end;
	logic          accept;
	logic          diff_now;
	logic [31:0]   body32;
	logic [31:0]   next32;
	logic [BW-1:0] bodies_inc;
	logic [7:0]    mask_new;
	logic          group_end;
	logic          over;

	logic [PW-1:0] pos_d;
	logic          differs_d;
	logic [BW-1:0] bodies_d;
	logic [7:0]    mask_d;
	logic          wb_d;
	logic          take_bank;

	// Handshake: hold off while the write bank drains or the job queue is full
	assign rec_end = (pos_q == PW'(RECORD_WORDS - 1));
	assign full    = busy_q[wb_q] || job_full;
	assign accept  = push && !full;

	// Record buffer write
	assign wr.en   = accept;
	assign wr.bank = wb_q;
	assign wr.data = item.target_word;
	assign wr_pos  = pos_q;

	// Record end classification
	always_comb begin
		diff_now   = differs_q || (item.base_word != item.target_word);
		body32     = 32'(bodies_q);
		bodies_inc = bodies_q + BW'(1);
		next32     = 32'(bodies_inc);
		over       = (body32 >= 32'(MAX_BODIES));
		mask_new   = mask_q | (diff_now ? (8'd1 << body32[GROUP_BITS-1:0]) : 8'd0);
		group_end  = (next32[GROUP_BITS-1:0] == '0);

		pos_d      = pos_q;
		differs_d  = differs_q;
		bodies_d   = bodies_q;
		mask_d     = mask_q;
		wb_d       = wb_q;
		take_bank  = 1'b0;
		job_push   = 1'b0;

		job          = '0;
		job.bank     = wb_q;
		job.body_idx = body32[11:0];
		job.mask     = mask_new;
		job.mask_idx = {body32[11:GROUP_BITS], GROUP_BITS'(0)};
		job.count    = next32;

		if (accept) begin
			if (rec_end) begin
				pos_d     = '0;
				differs_d = 1'b0;
				if (over) begin
					job_push = 1'b1;
					job.err  = 1'b1;
					bodies_d = '0;
					mask_d   = '0;
				end else begin
					job.words    = diff_now;
					job.mask_en  = group_end || item.final_word;
					job.count_en = item.final_word;
					job_push     = diff_now || group_end || item.final_word;
					bodies_d     = item.final_word ? '0 : bodies_inc;
					mask_d       = (group_end || item.final_word) ? 8'd0 : mask_new;
					if (diff_now) begin
						take_bank = 1'b1;
						wb_d      = !wb_q;
					end
				end
			end else if (item.final_word) begin
				// snapshot ended inside a record
				job_push  = 1'b1;
				job.err   = 1'b1;
				pos_d     = '0;
				differs_d = 1'b0;
				bodies_d  = '0;
				mask_d    = '0;
			end else begin
				pos_d     = pos_q + PW'(1);
				differs_d = diff_now;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			differs_q <= 1'b0;
			bodies_q  <= '0;
			mask_q    <= '0;
			wb_q      <= 1'b0;
			busy_q    <= '0;
		end else begin
			pos_q     <= pos_d;
			differs_q <= differs_d;
			bodies_q  <= bodies_d;
			mask_q    <= mask_d;
			wb_q      <= wb_d;
			if (rel.vld) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (take_bank) begin
				busy_q[wb_q] <= 1'b1;
			end
		end
	end

endmodule : sde_front
`default_nettype wire

[hdl/sde_jobq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_jobq - job queue between front and back end
// Small register FIFO; the user keeps depth a power of two, which the block does not enforce.
// ----------------------------------------------------------------------------
module sde_jobq import sde_pkg::*; #(
	parameter int DEPTH = SDE_JOBQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t wdata,
	output logic      full,
	input  wire logic rd,
	output job_t      rdata,
	output logic      empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule : sde_jobq
`default_nettype wire

[hdl/sde_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sde_back - result sequencer
// Holds the two record banks and walks each job (words, mask byte, body count
// or error) one result per cycle into the result register unless it stalls.
// ----------------------------------------------------------------------------
module sde_back import sde_pkg::*; #(
	parameter int RECORD_WORDS = SDE_RECORD_WORDS,
	localparam int PW = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wr_t           wr,
	input  wire logic [PW-1:0] wr_pos,
	input  wire job_t          job,
	input  wire logic          job_empty,
	output logic               job_pop,
	output rel_t               rel,
	output out_t               result,
	output logic               empty,
	input  wire logic          pop
);

	logic [31:0]   mem_q [2][RECORD_WORDS];
	logic [PW-1:0] word_idx_q;
	logic          words_done_q;
	logic          mask_done_q;
	logic          out_vld_q;
	out_t          out_q;

	logic          issue;
	logic          is_word;
	logic          last;
	logic          word_last;
	kind_t         sel_kind;
	logic [31:0]   sel_payload;
	logic [11:0]   sel_idx;

	assign empty  = !out_vld_q;
	assign result = out_q;
	assign issue  = !job_empty && (!out_vld_q || pop);

	// Record banks
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.bank][wr_pos] <= wr.data;
		end
	end

	// Pick the next result of the head job
	always_comb begin
		word_last   = (word_idx_q == PW'(RECORD_WORDS - 1));
		is_word     = 1'b0;
		last        = 1'b1;
		sel_kind    = KIND_COUNT;
		sel_payload = job.count;
		sel_idx     = '0;
		if (job.err) begin
			sel_kind    = KIND_ERROR;
			sel_payload = '0;
		end else if (job.words && !words_done_q) begin
			is_word  = 1'b1;
			sel_kind = KIND_WORD;
			sel_idx  = job.body_idx;
			last     = word_last && !job.mask_en && !job.count_en;
		end else if (job.mask_en && !mask_done_q) begin
			sel_kind    = KIND_MASK;
			sel_payload = {24'd0, job.mask};
			sel_idx     = job.mask_idx;
			last        = !job.count_en;
		end
		job_pop  = issue && last;
		rel.vld  = issue && is_word && word_last;
		rel.bank = job.bank;
	end

	// Sequencer position and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_idx_q   <= '0;
			words_done_q <= 1'b0;
			mask_done_q  <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (issue) begin
				out_vld_q <= 1'b1;
				if (last) begin
					word_idx_q   <= '0;
					words_done_q <= 1'b0;
					mask_done_q  <= 1'b0;
				end else if (is_word) begin
					if (word_last) begin
						word_idx_q   <= '0;
						words_done_q <= 1'b1;
					end else begin
						word_idx_q <= word_idx_q + PW'(1);
					end
				end else begin
					mask_done_q <= 1'b1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result register, record words read straight from the bank
	always_ff @(posedge clk) begin
		if (issue) begin
			out_q.kind       <= sel_kind;
			out_q.payload    <= is_word ? mem_q[job.bank][word_idx_q] : sel_payload;
			out_q.body_index <= sel_idx;
			out_q.run_end    <= last;
		end
	end

endmodule : sde_back
`default_nettype wire
